/* hdl/yhd_pkg.sv */
package yhd_pkg;

    // Item codes on the input channel.
    localparam logic [1:0] CMD_VELOCITY = 2'd0;
    localparam logic [1:0] CMD_ENCODER  = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_GAIN_PROP     = 3'd0;
    localparam logic [2:0] CFG_GAIN_INTEGRAL = 3'd1;
    localparam logic [2:0] CFG_GAIN_DERIV    = 3'd2;
    localparam logic [2:0] CFG_TURN_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT       = 3'd4;
    localparam logic [2:0] CFG_BASE_ADDR     = 3'd5;

    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS_DEFAULT = 12;

    // Division of the error by twenty, rounded: (|err| + 10) * 52429 >> 20.
    localparam int          DIV_ROUND   = 10;
    localparam logic [15:0] RECIP_20    = 16'd52429;
    localparam int          RECIP_SHIFT = 20;
    localparam int          DELTA_W     = 12;

    // Width of the correction sum before the fraction bits are dropped.
    localparam int CORR_SUM_W = 40;

    // Packet constants of the motor driver protocol.
    localparam logic [7:0] PKT_HEADER = 8'h55;
    localparam logic [7:0] SPEED_MAX  = 8'hFF;
    localparam int         SPEED_GAIN = 50;
    localparam int         SPEED_STOP = 127;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic signed [15:0] measured_yaw_rate;
    } t_in_item;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [3:0] address_byte;
        logic [7:0] speed_byte;
        logic [7:0] checksum_byte;
        logic       right_motor;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] gain_prop;
        logic signed [15:0] gain_integral;
        logic signed [15:0] gain_deriv;
        logic [14:0]        straight_turn_limit;
        logic [7:0]         timeout_ticks;
        logic [2:0]         motor_base_address;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_prop:           16'sd1229,
        gain_integral:       16'sd205,
        gain_deriv:          16'sd82,
        straight_turn_limit: 15'd205,
        timeout_ticks:       8'd10,
        motor_base_address:  3'd0
    };

    // Control flags that travel down the pipeline with each item.
    typedef struct packed {
        logic tick;
        logic pid;
    } t_ctl;

endpackage

/* hdl/yhd_front.sv */
module yhd_front #(
    parameter int FRAC_BITS = yhd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  yhd_pkg::t_in_item           i_item,
    input  yhd_pkg::t_cfg               i_cfg,
    output yhd_pkg::t_ctl               o_ctl,
    output logic signed [15:0]          o_lin,
    output logic signed [15:0]          o_ang,
    output logic signed [15:0]          o_err,
    output logic signed [FRAC_BITS+1:0] o_integ,
    output logic signed [16:0]          o_diff
);

    localparam int INT_W   = FRAC_BITS + 2;
    localparam int DELTA_W = yhd_pkg::DELTA_W;
    localparam int IACC_W  = ((INT_W > DELTA_W) ? INT_W : DELTA_W) + 1;
    localparam logic [16:0] LIN_MIN = 17'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic signed [IACC_W-1:0] ONE_POS = IACC_W'(1 << FRAC_BITS);
    localparam logic signed [IACC_W-1:0] ONE_NEG = -ONE_POS;

    logic signed [15:0]       r_held_lin;
    logic signed [15:0]       r_held_ang;
    logic signed [15:0]       r_held_yaw;
    logic                     r_seen;
    logic [7:0]               r_ticks;
    logic signed [INT_W-1:0]  r_integ;
    logic signed [15:0]       r_prev;

    logic                     go;
    logic                     tick_go;
    logic [7:0]               n_ticks;
    logic                     timeout;
    logic signed [16:0]       lin_ext;
    logic signed [16:0]       ang_ext;
    logic [16:0]              abs_lin;
    logic [16:0]              abs_ang;
    logic                     pid_on;
    logic signed [15:0]       err;
    logic [15:0]              mag;
    logic [15:0]              rnd;
    logic [31:0]              quot_prod;
    logic [DELTA_W-1:0]       quot;
    logic signed [DELTA_W-1:0] delta;
    logic signed [IACC_W-1:0] iacc;
    logic signed [IACC_W-1:0] iclamp;
    logic signed [INT_W-1:0]  integ_new;
    logic signed [16:0]       diff;

    assign go      = i_en && i_valid;
    assign tick_go = go && (i_item.cmd == yhd_pkg::CMD_TICK);

    always_comb begin
        n_ticks = (r_ticks == 8'hFF) ? r_ticks : r_ticks + 8'd1;
        timeout = n_ticks > i_cfg.timeout_ticks;

        lin_ext = 17'(r_held_lin);
        ang_ext = 17'(r_held_ang);
        abs_lin = lin_ext[16] ? 17'(-lin_ext) : 17'(lin_ext);
        abs_ang = ang_ext[16] ? 17'(-ang_ext) : 17'(ang_ext);
        pid_on  = (abs_lin > LIN_MIN) && (abs_ang < {2'b00, i_cfg.straight_turn_limit})
                  && r_seen && !timeout;

        // The error is the negated yaw rate; the most negative rate saturates.
        err = (r_held_yaw == 16'sh8000) ? 16'sh7FFF : -r_held_yaw;
        mag = err[15] ? 16'(-err) : 16'(err);
        rnd = mag + 16'(yhd_pkg::DIV_ROUND);
        quot_prod = 32'(rnd) * 32'(yhd_pkg::RECIP_20);
        quot  = quot_prod[yhd_pkg::RECIP_SHIFT +: DELTA_W];
        delta = err[15] ? -$signed(quot) : $signed(quot);

        iacc = IACC_W'(r_integ) + IACC_W'(delta);
        if (iacc > ONE_POS) begin
            iclamp = ONE_POS;
        end else if (iacc < ONE_NEG) begin
            iclamp = ONE_NEG;
        end else begin
            iclamp = iacc;
        end
        integ_new = INT_W'(iclamp);

        diff = 17'(err) - 17'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lin <= '0;
            r_held_ang <= '0;
            r_held_yaw <= '0;
            r_seen     <= 1'b0;
            r_ticks    <= '0;
            r_integ    <= '0;
            r_prev     <= '0;
        end else if (go) begin
            unique case (i_item.cmd)
                yhd_pkg::CMD_VELOCITY: begin
                    r_held_lin <= i_item.linear_speed;
                    r_held_ang <= i_item.angular_speed;
                    r_ticks    <= '0;
                end
                yhd_pkg::CMD_ENCODER: begin
                    r_held_yaw <= i_item.measured_yaw_rate;
                    r_seen     <= 1'b1;
                end
                yhd_pkg::CMD_TICK: begin
                    r_ticks <= n_ticks;
                    if (pid_on) begin
                        r_integ <= integ_new;
                        r_prev  <= err;
                    end else begin
                        r_integ <= '0;
                        r_prev  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl.tick <= tick_go;
            o_ctl.pid  <= pid_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lin   <= timeout ? 16'sd0 : r_held_lin;
            o_ang   <= timeout ? 16'sd0 : r_held_ang;
            o_err   <= err;
            o_integ <= integ_new;
            o_diff  <= diff;
        end
    end

    a_pid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go && !pid_on |=> (r_integ == '0) && (r_prev == '0))
        else $error("PID state not cleared after a tick without correction");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |=> r_ticks != 8'd0)
        else $error("tick counter did not advance");

endmodule

/* hdl/yhd_mult.sv */
module yhd_mult #(
    parameter int FRAC_BITS = yhd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  yhd_pkg::t_ctl                 i_ctl,
    input  logic signed [15:0]            i_lin,
    input  logic signed [15:0]            i_ang,
    input  logic signed [15:0]            i_err,
    input  logic signed [FRAC_BITS+1:0]   i_integ,
    input  logic signed [16:0]            i_diff,
    input  yhd_pkg::t_cfg                 i_cfg,
    output yhd_pkg::t_ctl                 o_ctl,
    output logic signed [15:0]            o_lin,
    output logic signed [15:0]            o_ang,
    output logic signed [31:0]            o_p_kp,
    output logic signed [FRAC_BITS+17:0]  o_p_ki,
    output logic signed [32:0]            o_p_kd
);

    localparam int KI_W = FRAC_BITS + 18;

    logic signed [31:0]     m_kp;
    logic signed [KI_W-1:0] m_ki;
    logic signed [32:0]     m_kd;

    // Three independent products; the derivative factor of twenty comes later.
    assign m_kp = 32'(i_cfg.gain_prop) * 32'(i_err);
    assign m_ki = KI_W'(i_cfg.gain_integral) * KI_W'(i_integ);
    assign m_kd = 33'(i_cfg.gain_deriv) * 33'(i_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lin  <= i_lin;
            o_ang  <= i_ang;
            o_p_kp <= m_kp;
            o_p_ki <= m_ki;
            o_p_kd <= m_kd;
        end
    end

endmodule

/* hdl/yhd_mix.sv */
module yhd_mix #(
    parameter int FRAC_BITS = yhd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  yhd_pkg::t_ctl                                 i_ctl,
    input  logic signed [15:0]                            i_lin,
    input  logic signed [15:0]                            i_ang,
    input  logic signed [31:0]                            i_p_kp,
    input  logic signed [FRAC_BITS+17:0]                  i_p_ki,
    input  logic signed [32:0]                            i_p_kd,
    output logic                                          o_tick,
    output logic signed [15:0]                            o_v,
    output logic signed [yhd_pkg::CORR_SUM_W-FRAC_BITS:0] o_w
);

    localparam int SUM_W  = yhd_pkg::CORR_SUM_W;
    localparam int CORR_W = SUM_W - FRAC_BITS;
    localparam int W_W    = CORR_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1 << (FRAC_BITS - 1));

    logic signed [SUM_W-1:0]  kd_x;
    logic signed [SUM_W-1:0]  sum;
    logic signed [CORR_W-1:0] corr;
    logic signed [W_W-1:0]    w;

    always_comb begin
        kd_x = SUM_W'(i_p_kd);
        sum  = SUM_W'(i_p_kp) + SUM_W'(i_p_ki) + (kd_x <<< 4) + (kd_x <<< 2) + ROUND;
        // Dropping the fraction bits of a two's complement value rounds down.
        corr = $signed(sum[SUM_W-1:FRAC_BITS]);
        w    = i_ctl.pid ? W_W'(i_ang) + W_W'(corr) : W_W'(i_ang);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tick <= 1'b0;
        end else if (i_en) begin
            o_tick <= i_ctl.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v <= i_lin;
            o_w <= w;
        end
    end

endmodule

/* hdl/yhd_pack.sv */
module yhd_pack #(
    parameter int FRAC_BITS = yhd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_tick,
    input  logic signed [15:0]                            i_v,
    input  logic signed [yhd_pkg::CORR_SUM_W-FRAC_BITS:0] i_w,
    input  logic [2:0]                                    i_base,
    input  logic                                          i_out_stall,
    output logic                                          o_out_valid,
    output yhd_pkg::t_out_item                            o_out_item,
    output logic                                          o_load_ok
);

    localparam int W_W = yhd_pkg::CORR_SUM_W - FRAC_BITS + 1;
    localparam int S_W = W_W + 1;
    localparam int X_W = S_W + 7;
    localparam int T_W = X_W - FRAC_BITS;
    localparam logic signed [X_W-1:0] OFFSET = X_W'(yhd_pkg::SPEED_STOP << FRAC_BITS);
    localparam logic signed [X_W-1:0] BIAS   = X_W'((1 << FRAC_BITS) - 1);

    logic       r_ov;
    logic       r_right;
    logic [7:0] r_spd_l;
    logic [7:0] r_spd_r;

    logic signed [S_W-1:0] s_l;
    logic signed [S_W-1:0] s_r;
    logic                  load;
    logic [3:0]            addr;
    logic [7:0]            spd;

    // Speed byte: fifty times the wheel speed plus the stop code, rounded
    // toward zero and clamped to a byte.
    function automatic logic [7:0] speed_of(input logic signed [S_W-1:0] s);
        logic signed [X_W-1:0] xs;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] xb;
        logic signed [T_W-1:0] t;
        xs = X_W'(s);
        x  = (xs <<< 5) + (xs <<< 4) + (xs <<< 1) + OFFSET;
        xb = x[X_W-1] ? x + BIAS : x;
        t  = $signed(xb[X_W-1:FRAC_BITS]);
        if (t[T_W-1]) begin
            speed_of = 8'd0;
        end else if (|t[T_W-2:8]) begin
            speed_of = yhd_pkg::SPEED_MAX;
        end else begin
            speed_of = t[7:0];
        end
    endfunction

    assign s_l = S_W'(i_v) - S_W'(i_w);
    assign s_r = S_W'(i_v) + S_W'(i_w);

    // A new pair may enter once the register is empty or its right packet leaves.
    assign o_load_ok = !r_ov || (r_right && !i_out_stall);
    assign load      = o_load_ok && i_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_right <= 1'b0;
        end else if (load) begin
            r_ov    <= 1'b1;
            r_right <= 1'b0;
        end else if (r_ov && !i_out_stall) begin
            if (r_right) begin
                r_ov <= 1'b0;
            end else begin
                r_right <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_spd_l <= speed_of(s_l);
            r_spd_r <= speed_of(s_r);
        end
    end

    always_comb begin
        addr = {r_right, i_base};
        spd  = r_right ? r_spd_r : r_spd_l;
        o_out_item.header_byte   = yhd_pkg::PKT_HEADER;
        o_out_item.address_byte  = addr;
        o_out_item.speed_byte    = spd;
        o_out_item.checksum_byte = yhd_pkg::PKT_HEADER + {4'b0000, addr} + spd;
        o_out_item.right_motor   = r_right;
        o_out_item.last          = r_right;
    end

    assign o_out_valid = r_ov;

    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_right |=> r_ov)
        else $error("left packet not followed by a right packet");

    a_right_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_right && !i_out_stall |=> r_ov && r_right)
        else $error("right packet missing after the left one was taken");

    a_load_starts_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_ov && !r_right)
        else $error("new pair did not start with the left packet");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_right && !i_out_stall && !i_tick |=> !r_ov)
        else $error("output register not emptied after the right packet");

endmodule

/* hdl/yaw_hold_diff_drive_packetizer.sv */
// Yaw-hold differential drive packetizer.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): a velocity
// command stores the linear and turn speeds, an encoder item stores the
// measured yaw rate, a control tick produces a pair of motor packets.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): for every
// tick the left packet and then the right packet, the right one marked last.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) and
// must only be used while no transaction is in flight.
//
// Path: the left packet of a tick passes the input register, the front, mult
// and mix stage registers and the output register; the right packet follows
// once the left one is taken. A tick holds the pipeline until both packets
// leave the single output register, one packet a cycle while the receiver
// does not stall; velocity and encoder transactions do not hold it.
//
// Reset clears the held speeds, the yaw rate, the seen flag, the tick counter
// and the PID state, and loads the default gains and limits. When the receiver
// stalls, the output register holds its packet and the whole pipeline freezes,
// which raises o_in_stall in the same cycle.
module yaw_hold_diff_drive_packetizer #(
    parameter int FRAC_BITS = yhd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  yhd_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output yhd_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [yhd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int INT_W = FRAC_BITS + 2;
    localparam int KI_W  = FRAC_BITS + 18;
    localparam int W_W   = yhd_pkg::CORR_SUM_W - FRAC_BITS + 1;

    yhd_pkg::t_cfg     r_cfg;
    logic              r_in_valid;
    yhd_pkg::t_in_item r_in_item;

    // One enable moves every stage; it falls only while a packet pair is
    // still waiting in the output register.
    logic en;

    yhd_pkg::t_ctl           s1_ctl;
    logic signed [15:0]      s1_lin;
    logic signed [15:0]      s1_ang;
    logic signed [15:0]      s1_err;
    logic signed [INT_W-1:0] s1_integ;
    logic signed [16:0]      s1_diff;

    yhd_pkg::t_ctl           s2_ctl;
    logic signed [15:0]      s2_lin;
    logic signed [15:0]      s2_ang;
    logic signed [31:0]      s2_p_kp;
    logic signed [KI_W-1:0]  s2_p_ki;
    logic signed [32:0]      s2_p_kd;

    logic                    s3_tick;
    logic signed [15:0]      s3_v;
    logic signed [W_W-1:0]   s3_w;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= yhd_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                yhd_pkg::CFG_GAIN_PROP:     r_cfg.gain_prop <= $signed(i_cfg_data);
                yhd_pkg::CFG_GAIN_INTEGRAL: r_cfg.gain_integral <= $signed(i_cfg_data);
                yhd_pkg::CFG_GAIN_DERIV:    r_cfg.gain_deriv <= $signed(i_cfg_data);
                yhd_pkg::CFG_TURN_LIMIT:    r_cfg.straight_turn_limit <= i_cfg_data[14:0];
                yhd_pkg::CFG_TIMEOUT:       r_cfg.timeout_ticks <= i_cfg_data[7:0];
                yhd_pkg::CFG_BASE_ADDR:     r_cfg.motor_base_address <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = !en;

    // Input register: a transaction lands here and is then processed against the
    // held state by the front stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item <= i_in_item;
        end
    end

    yhd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_ctl   (s1_ctl),
        .o_lin   (s1_lin),
        .o_ang   (s1_ang),
        .o_err   (s1_err),
        .o_integ (s1_integ),
        .o_diff  (s1_diff)
    );

    yhd_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s1_ctl),
        .i_lin   (s1_lin),
        .i_ang   (s1_ang),
        .i_err   (s1_err),
        .i_integ (s1_integ),
        .i_diff  (s1_diff),
        .i_cfg   (r_cfg),
        .o_ctl   (s2_ctl),
        .o_lin   (s2_lin),
        .o_ang   (s2_ang),
        .o_p_kp  (s2_p_kp),
        .o_p_ki  (s2_p_ki),
        .o_p_kd  (s2_p_kd)
    );

    yhd_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s2_ctl),
        .i_lin   (s2_lin),
        .i_ang   (s2_ang),
        .i_p_kp  (s2_p_kp),
        .i_p_ki  (s2_p_ki),
        .i_p_kd  (s2_p_kd),
        .o_tick  (s3_tick),
        .o_v     (s3_v),
        .o_w     (s3_w)
    );

    yhd_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (s3_tick),
        .i_v         (s3_v),
        .i_w         (s3_w),
        .i_base      (r_cfg.motor_base_address),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_load_ok   (en)
    );

endmodule

/* test/drive_packet_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port of the packetizer. Every
// accepted control tick is turned into the pair of motor packets that the
// block should send, and every packet that leaves the block is compared with
// the oldest of those still waiting.
module drive_packet_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  yhd_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  yhd_pkg::t_out_item             i_out_item,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_idx,
    input  logic [yhd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam int         FRAC        = yhd_pkg::FRAC_BITS_DEFAULT;
    localparam int         ONE_Q       = 1 << FRAC;
    localparam int         LIN_MIN     = (ONE_Q + 50) / 100;
    localparam int         ERR_MAX     = 32767;
    localparam int         DERIV_SCALE = 20;
    localparam logic [7:0] TICK_SAT    = 8'hFF;

    yhd_pkg::t_cfg      regs;
    logic signed [15:0] held_lin;
    logic signed [15:0] held_ang;
    logic signed [15:0] held_yaw;
    logic               yaw_seen;
    logic [7:0]         tick_count;
    int                 integ_q;
    int                 prev_err;
    yhd_pkg::t_out_item expected_packets[$];

    // Speed in Q form to a driver byte: 127 + 50 * speed, cut toward zero.
    function automatic logic [7:0] speed_to_byte(input longint speed);
        longint scaled;
        longint whole;
        scaled = speed * yhd_pkg::SPEED_GAIN + (longint'(yhd_pkg::SPEED_STOP) <<< FRAC);
        whole  = (scaled >= 0) ? (scaled >>> FRAC) : -((-scaled) >>> FRAC);
        if (whole < 0) begin
            whole = 0;
        end
        if (whole > longint'(yhd_pkg::SPEED_MAX)) begin
            whole = longint'(yhd_pkg::SPEED_MAX);
        end
        return whole[7:0];
    endfunction

    task automatic queue_packet(input logic right, input logic [7:0] spd);
        yhd_pkg::t_out_item pkt;
        pkt.header_byte   = yhd_pkg::PKT_HEADER;
        pkt.address_byte  = {right, regs.motor_base_address};
        pkt.speed_byte    = spd;
        pkt.checksum_byte = yhd_pkg::PKT_HEADER + pkt.address_byte + spd;
        pkt.right_motor   = right;
        pkt.last          = right;
        expected_packets.push_back(pkt);
    endtask

    task automatic queue_pair(input longint lin, input longint ang);
        queue_packet(1'b0, speed_to_byte(lin - ang));
        queue_packet(1'b1, speed_to_byte(lin + ang));
    endtask

    task automatic predict_motor_packets(input yhd_pkg::t_in_item item);
        int     abs_lin;
        int     abs_ang;
        int     err;
        int     delta;
        longint corr;
        case (item.cmd)
            yhd_pkg::CMD_VELOCITY: begin
                held_lin   = item.linear_speed;
                held_ang   = item.angular_speed;
                tick_count = '0;
            end
            yhd_pkg::CMD_ENCODER: begin
                held_yaw = item.measured_yaw_rate;
                yaw_seen = 1'b1;
            end
            yhd_pkg::CMD_TICK: begin
                if (tick_count != TICK_SAT) begin
                    tick_count++;
                end
                abs_lin = (held_lin < 0) ? -int'(held_lin) : int'(held_lin);
                abs_ang = (held_ang < 0) ? -int'(held_ang) : int'(held_ang);
                if (tick_count > regs.timeout_ticks) begin
                    integ_q  = 0;
                    prev_err = 0;
                    queue_pair(0, 0);
                end else if (!(abs_lin > LIN_MIN && abs_ang < int'(regs.straight_turn_limit))
                             || !yaw_seen) begin
                    integ_q  = 0;
                    prev_err = 0;
                    queue_pair(held_lin, held_ang);
                end else begin
                    // Yaw hold: the error is the negated yaw rate, which only
                    // leaves 16 bits when the rate is the most negative value.
                    err = -int'(held_yaw);
                    if (err > ERR_MAX) begin
                        err = ERR_MAX;
                    end
                    delta = (err >= 0) ? (err + yhd_pkg::DIV_ROUND) / DERIV_SCALE
                                       : -((-err + yhd_pkg::DIV_ROUND) / DERIV_SCALE);
                    integ_q += delta;
                    if (integ_q > ONE_Q) begin
                        integ_q = ONE_Q;
                    end
                    if (integ_q < -ONE_Q) begin
                        integ_q = -ONE_Q;
                    end
                    corr = longint'($signed(regs.gain_prop)) * err
                         + longint'($signed(regs.gain_integral)) * integ_q
                         + longint'($signed(regs.gain_deriv))
                           * (longint'(err - prev_err) * DERIV_SCALE);
                    corr = (corr + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
                    prev_err = err;
                    queue_pair(held_lin, longint'(held_ang) + corr);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        yhd_pkg::t_out_item want;
        if (!i_rst_n) begin
            regs         = yhd_pkg::CFG_RESET;
            held_lin     = '0;
            held_ang     = '0;
            held_yaw     = '0;
            yaw_seen     = 1'b0;
            tick_count   = '0;
            integ_q      = 0;
            prev_err     = 0;
            o_mismatches = 0;
            expected_packets.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    yhd_pkg::CFG_GAIN_PROP:     regs.gain_prop           = i_cfg_data;
                    yhd_pkg::CFG_GAIN_INTEGRAL: regs.gain_integral       = i_cfg_data;
                    yhd_pkg::CFG_GAIN_DERIV:    regs.gain_deriv          = i_cfg_data;
                    yhd_pkg::CFG_TURN_LIMIT:    regs.straight_turn_limit = i_cfg_data[14:0];
                    yhd_pkg::CFG_TIMEOUT:       regs.timeout_ticks       = i_cfg_data[7:0];
                    yhd_pkg::CFG_BASE_ADDR:     regs.motor_base_address  = i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_packets.size() == 0) begin
                    $display("%0t: packet expected none, got %p", $time, i_out_item);
                    o_mismatches++;
                end else begin
                    want = expected_packets.pop_front();
                    check_field("header_byte", want.header_byte, i_out_item.header_byte);
                    check_field("address_byte", want.address_byte, i_out_item.address_byte);
                    check_field("speed_byte", want.speed_byte, i_out_item.speed_byte);
                    check_field("checksum_byte", want.checksum_byte,
                                i_out_item.checksum_byte);
                    check_field("right_motor", want.right_motor, i_out_item.right_motor);
                    check_field("last", want.last, i_out_item.last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_motor_packets(i_in_item);
            end
        end
        o_outstanding = expected_packets.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Top of the packetizer testbench. It only makes stimulus: velocity, encoder
// and tick transactions on the input channel, register writes between phases
// and a stall pattern on the packet channel. The checker beside the block
// predicts every packet and counts mismatches; the verdict is given here.
module tb_top;

    // Cycles without any transaction before the run is declared hung. The
    // slowest correct stretch is a sender gap or a block of stalls plus the
    // pipeline, so this is far beyond it.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pipeline depth of the block plus the right packet, with some margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES = 6;
    localparam int SATURATION_TICKS = 300;
    localparam int STRAIGHT_MIN = ((1 << yhd_pkg::FRAC_BITS_DEFAULT) + 50) / 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] CFG_SPARE_IDX = 3'd6;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCKS
    } t_stall_mode;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    yhd_pkg::t_in_item              in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    yhd_pkg::t_out_item             out_item;
    logic                           cfg_we = 1'b0;
    logic [2:0]                     cfg_idx = yhd_pkg::CFG_GAIN_PROP;
    logic [yhd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             mismatches;
    int                             outstanding;

    int          burst_left = 0;
    int          idle_cycles = 0;
    int          cycle_no = 0;
    int          stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    yaw_hold_diff_drive_packetizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    drive_packet_checker packet_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver picks a new behaviour at random intervals: no stalls at
    // all, occasional stalls, mostly stalled, or regular blocks of stall that
    // freeze the pipeline over consecutive cycles.
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 160);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((cycle_no % 16) < 11);
        endcase
    end

    // Any transaction on either channel shows that the block is still alive.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Presents one transaction and waits for the edge that accepts it. The
    // sender works in bursts; when a burst runs out it may drop valid for a
    // random gap, and otherwise it carries straight on with the next burst.
    task automatic send_item(input yhd_pkg::t_in_item item);
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input int lin, input int ang,
                            input int yaw);
        yhd_pkg::t_in_item item;
        item.cmd               = cmd;
        item.linear_speed      = 16'(lin);
        item.angular_speed     = 16'(ang);
        item.measured_yaw_rate = 16'(yaw);
        send_item(item);
    endtask

    // Lowers valid and waits until every packet the checker predicts has
    // left the block, then lets the pipeline run empty of velocity and
    // encoder transactions, which produce no packet to wait for.
    task automatic wait_for_packets();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The write enable is left high between back-to-back writes and lowered
    // once the whole set has gone in.
    task automatic write_reg(input logic [2:0] idx,
                             input logic [yhd_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Unused upper data bits are filled with noise since the block must drop
    // them, and a write to an index with no register behind it is slipped in.
    task automatic write_config(input yhd_pkg::t_cfg setting);
        write_reg(yhd_pkg::CFG_GAIN_PROP, setting.gain_prop);
        write_reg(yhd_pkg::CFG_GAIN_INTEGRAL, setting.gain_integral);
        write_reg(yhd_pkg::CFG_GAIN_DERIV, setting.gain_deriv);
        write_reg(yhd_pkg::CFG_TURN_LIMIT, {1'($urandom), setting.straight_turn_limit});
        write_reg(yhd_pkg::CFG_TIMEOUT, {8'($urandom), setting.timeout_ticks});
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        write_reg(yhd_pkg::CFG_BASE_ADDR, {13'($urandom), setting.motor_base_address});
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_gain();
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 4096) - 2048);
    endfunction

    function automatic yhd_pkg::t_cfg random_config();
        yhd_pkg::t_cfg setting;
        setting.gain_prop          = pick_gain();
        setting.gain_integral      = pick_gain();
        setting.gain_deriv         = pick_gain();
        setting.straight_turn_limit = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                                   : 15'($urandom_range(0, 2048));
        setting.timeout_ticks      = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 12));
        setting.motor_base_address = 3'($urandom);
        return setting;
    endfunction

    // Mostly values around the interesting range, with some full-range
    // noise, the two extremes and the edge of the straight-ahead speed.
    function automatic logic signed [15:0] pick_value(input int span);
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 1) ? 32767 : -32768;
            2:       v = ($urandom_range(0, 1) ? 1 : -1) * (STRAIGHT_MIN + $urandom_range(0, 1));
            default: v = $urandom_range(0, 2 * span) - span;
        endcase
        return 16'(v);
    endfunction

    function automatic yhd_pkg::t_in_item random_item(input int vel_pct, input int turn_span);
        yhd_pkg::t_in_item item;
        int                roll;
        item.linear_speed      = pick_value(8192);
        item.angular_speed     = pick_value(turn_span);
        item.measured_yaw_rate = pick_value(3000);
        roll = $urandom_range(0, 99);
        if (roll < vel_pct) begin
            item.cmd = yhd_pkg::CMD_VELOCITY;
        end else if (roll < vel_pct + 20) begin
            item.cmd = yhd_pkg::CMD_ENCODER;
        end else if (roll < 96) begin
            item.cmd = yhd_pkg::CMD_TICK;
        end else begin
            item.cmd = CMD_UNUSED;
        end
        return item;
    endfunction

    initial begin
        yhd_pkg::t_cfg setting;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset settings. A tick with nothing stored
        // sends two stop packets; full-scale commands clamp the speed bytes.
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_VELOCITY, 32767, 0, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_VELOCITY, -32768, 32767, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        // An unknown command must leave everything untouched.
        send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom);
        // The most negative yaw rate, whose negation does not fit, then a
        // couple of straight ticks so that the integral builds up.
        send_cmd(yhd_pkg::CMD_ENCODER, 0, 0, -32768);
        send_cmd(yhd_pkg::CMD_VELOCITY, 4096, 0, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_ENCODER, 0, 0, 32767);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        // Either side of the straight-ahead thresholds on speed and turn.
        send_cmd(yhd_pkg::CMD_VELOCITY, STRAIGHT_MIN, 0, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_VELOCITY, -(STRAIGHT_MIN + 1),
                 yhd_pkg::CFG_RESET.straight_turn_limit - 1, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_VELOCITY, STRAIGHT_MIN + 1,
                 yhd_pkg::CFG_RESET.straight_turn_limit, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(yhd_pkg::CMD_VELOCITY, -(STRAIGHT_MIN + 1),
                 1 - yhd_pkg::CFG_RESET.straight_turn_limit, 0);
        send_cmd(yhd_pkg::CMD_TICK, 0, 0, 0);
        wait_for_packets();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: setting = '{16'sd32767, 16'sd32767, 16'sd32767, 15'h7FFF, 8'hFF, 3'd7};
                1: setting = '{-16'sd32768, -16'sd32768, -16'sd32768, 15'h7FFF, 8'hFE, 3'd5};
                2: setting = '{16'sd32767, -16'sd32768, 16'sd0, 15'd0, 8'd0, 3'd0};
                3: setting = yhd_pkg::CFG_RESET;
                default: setting = random_config();
            endcase
            write_config(setting);

            if (phase == 0) begin
                // With the longest timeout the tick counter saturates and
                // the motors must never be stopped, however long it runs.
                send_cmd(yhd_pkg::CMD_VELOCITY, 4096, 100, 0);
                repeat (SATURATION_TICKS) begin
                    send_cmd(($urandom_range(0, 19) == 0) ? yhd_pkg::CMD_ENCODER
                                                          : yhd_pkg::CMD_TICK,
                             0, 0, pick_value(3000));
                end
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item(25, int'(setting.straight_turn_limit) + 64));
                // Half way through, hold the sender back until the block has
                // sent out everything it owes.
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_for_packets();
                end
            end
            wait_for_packets();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
